>>> hw/rtl/slt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg: shared types for the sorted list table
// Operation and status codes, controller states and the command bundle that
// the controller drives into the datapath.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int VALUE_W     = 32;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_POP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic load;     // capture a new request
    logic compare;  // register the per-cell compare results
    logic execute;  // apply the update and load the result register
  } dp_cmd_t;

endpackage

>>> hw/rtl/sorted_list_table.sv
`timescale 1ns / 1ps
// A request is captured, the cell row then registers its compare, and then it executes;
// a new request is not taken before the last one reaches its execute step, so
// requests do not overlap; a stalled result holds the execute step.
// Reset: synchronous, active low; empties the table and drops any pending result.
// Stored values are never cleared; only slots below the entry count are used.
// ----------------------------------------------------------------------------
// sorted_list_table: bounded ascending table used as a priority queue
// Insert, search, delete and pop on signed 32-bit values held in sorted order
// in a row of cells; every result carries the entry count after the request.
// ----------------------------------------------------------------------------
module sorted_list_table #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_operation,
  input  logic signed [slt_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic signed [slt_pkg::VALUE_W-1:0]  out_popped_value,
  output logic [slt_pkg::COUNT_OUT_W-1:0]     out_entry_count
);
  import slt_pkg::*;

  // Commands from the sequencer to the cell row. The sequencer captures a
  // request, lets every cell register its compare against the request value
  // in the next cycle, and then, once the result register is free, applies
  // the shift and loads the result register. The result register parts the two sides:
  // a new request is taken in the same cycle that a result is loaded.
  dp_cmd_t cmd;

  slt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // The cell row keeps the entries in ascending order. Because the order is
  // kept at all times, each cell decides its own move from its compare bit
  // and that of its neighbor; equal values stay grouped, so the first cell
  // that is not less than the value is also the first equal one.
  slt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_entry_count  (out_entry_count)
  );

endmodule

>>> hw/rtl/slt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_ctrl: sequencer of the sorted list table
// Steps each request through compare and execute and owns both handshakes.
// ----------------------------------------------------------------------------
module slt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output slt_pkg::dp_cmd_t cmd
);
  import slt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_load;

  assign can_load  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        if (can_load) begin
          // The result register is free, so finish and take the next request.
          cmd.execute   = 1'b1;
          out_valid_nxt = 1'b1;
          in_ready      = 1'b1;
          if (in_valid) begin
            cmd.load  = 1'b1;
            state_nxt = S_CMP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/slt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_datapath: row of sorted cells with compare and shift
// Each cell compares its entry against the request value and moves left,
// right or takes the new value from what it and its neighbors report.
// ----------------------------------------------------------------------------
module slt_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  slt_pkg::dp_cmd_t                    cmd,
  input  logic [1:0]                          in_operation,
  input  logic signed [slt_pkg::VALUE_W-1:0]  in_value,
  output logic [1:0]                          out_status,
  output logic signed [slt_pkg::VALUE_W-1:0]  out_popped_value,
  output logic [slt_pkg::COUNT_OUT_W-1:0]     out_entry_count
);
  import slt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  op_t                        op_r;
  logic signed [VALUE_W-1:0]  val_r;
  logic signed [VALUE_W-1:0]  entry_r   [CAPACITY];
  logic signed [VALUE_W-1:0]  entry_nxt [CAPACITY];
  logic [CW-1:0]              count_r, count_nxt;
  logic [CAPACITY-1:0]        lt_r, hit_r;
  logic [CAPACITY-1:0]        lt_now, hit_now;
  status_t                    status_r, status_nxt;
  logic signed [VALUE_W-1:0]  popped_r, popped_nxt;
  logic [CW-1:0]              cnt_out_r;
  logic [31:0]                cnt_ext;
  logic                       full, empty, found;

  assign full  = (count_r == CW'(CAPACITY));
  assign empty = (count_r == '0);
  assign found = |hit_r;

  // Per-cell compare. Sorted order makes lt monotonic, so the first cell
  // that is not less than the value is where insert and delete act.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cmp
    logic valid;
    assign valid     = (count_r > CW'(g));
    assign lt_now[g] = valid && (entry_r[g] < val_r);
    if (g == 0) begin : g_first
      assign hit_now[g] = valid && (entry_r[g] == val_r);
    end else begin : g_rest
      assign hit_now[g] = valid && (entry_r[g] == val_r) && lt_now[g-1];
    end
  end

  // Next value of each cell.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entry_nxt[i] = entry_r[i];
      case (op_r)
        OP_INSERT: begin
          if (!full && !lt_r[i]) begin
            if ((i == 0) || lt_r[(i == 0) ? 0 : i-1]) begin
              entry_nxt[i] = val_r;
            end else begin
              entry_nxt[i] = entry_r[(i == 0) ? 0 : i-1];
            end
          end
        end
        OP_DELETE: begin
          if (found && !lt_r[i] && (i < CAPACITY-1)) begin
            entry_nxt[i] = entry_r[(i < CAPACITY-1) ? i+1 : i];
          end
        end
        OP_POP: begin
          if (!empty && (i < CAPACITY-1)) begin
            entry_nxt[i] = entry_r[(i < CAPACITY-1) ? i+1 : i];
          end
        end
        default: begin
          entry_nxt[i] = entry_r[i];
        end
      endcase
    end
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    popped_nxt = '0;
    case (op_r)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      OP_SEARCH: begin
        status_nxt = found ? ST_OK : ST_NOT_FOUND;
      end
      OP_DELETE: begin
        if (found) begin
          count_nxt = count_r - 1'b1;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      OP_POP: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          popped_nxt = entry_r[0];
          count_nxt  = count_r - 1'b1;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_operation);
      val_r <= in_value;
    end
    if (cmd.compare) begin
      lt_r  <= lt_now;
      hit_r <= hit_now;
    end
    if (cmd.execute) begin
      for (int i = 0; i < CAPACITY; i++) begin
        entry_r[i] <= entry_nxt[i];
      end
      status_r  <= status_nxt;
      popped_r  <= popped_nxt;
      cnt_out_r <= count_nxt;
    end
  end

  assign cnt_ext          = 32'(cnt_out_r);
  assign out_status       = status_r;
  assign out_popped_value = popped_r;
  assign out_entry_count  = cnt_ext[COUNT_OUT_W-1:0];

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && (op_r == OP_INSERT) && !full |=> count_r == $past(count_r) + 1'b1)
    else $error("insert into a table with room did not add an entry");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && (op_r == OP_POP) && empty |=>
      (out_status == ST_EMPTY) && (out_popped_value == '0))
    else $error("pop of an empty table reported wrongly");
`endif

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sorted list table
// Streams insert, search, delete and pop requests into the table with random
// gaps and random result back-pressure, keeps its own ordered copy of the
// table, and checks every result field against that copy in request order.
// ----------------------------------------------------------------------------
module tb_top;
  import slt_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int RANDOM_ITEMS = 500;
  localparam int SETTLE_CYCLES = 8;

  // One request as queued for the driver.
  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
  } request_t;

  // One result as the table should return it.
  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] popped;
    logic [COUNT_OUT_W-1:0]    count;
  } table_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                       in_valid     = 1'b0;
  logic                       in_ready;
  logic [1:0]                 in_operation = '0;
  logic signed [VALUE_W-1:0]  in_value     = '0;
  logic                       out_valid;
  logic                       out_ready    = 1'b0;
  logic [1:0]                 out_status;
  logic signed [VALUE_W-1:0]  out_popped_value;
  logic [COUNT_OUT_W-1:0]     out_entry_count;

  sorted_list_table #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_popped_value(out_popped_value),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Requests waiting to be driven, and results the table still owes us.
  request_t      pending_reqs[$];
  table_result_t expected_results[$];
  int            error_count = 0;

  // Our own copy of the table contents, kept in ascending order.
  logic signed [VALUE_W-1:0] held_values[CAPACITY];
  int                        held_count = 0;

  // Values that have been inserted by the stimulus, so that later searches
  // and deletes often hit a stored entry.
  logic signed [VALUE_W-1:0] inserted_history[$];

  // Per-side count of remaining items in a stretch with no idling at all.
  // Index 0 is the request side, index 1 the result side.
  int quiet_left[2] = '{0, 0};

  // Wait cycles for one item: usually a random draw, but now and then a run of
  // items with no idling so that back-to-back traffic is exercised too.
  function automatic int draw_wait(input int side);
    if (quiet_left[side] > 0) begin
      quiet_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      quiet_left[side] = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Applies one accepted request to the table copy and queues its result.
  task automatic predict_request(input logic [1:0] op_bits,
                                 input logic signed [VALUE_W-1:0] v);
    table_result_t res;
    int            pos;
    int            idx;
    res.status = ST_OK;
    res.popped = '0;
    pos = -1;
    case (op_t'(op_bits))
      OP_INSERT: begin
        if (held_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // A new value goes in front of any equal values already held.
          pos = 0;
          while (pos < held_count && held_values[pos] < v) pos++;
          for (idx = held_count; idx > pos; idx--) held_values[idx] = held_values[idx-1];
          held_values[pos] = v;
          held_count++;
        end
      end
      OP_SEARCH, OP_DELETE: begin
        for (idx = 0; idx < held_count && pos < 0; idx++) begin
          if (held_values[idx] == v) pos = idx;
        end
        if (pos < 0) begin
          res.status = ST_NOT_FOUND;
        end else if (op_t'(op_bits) == OP_DELETE) begin
          // Only the first of several equal entries is removed.
          for (idx = pos; idx + 1 < held_count; idx++) held_values[idx] = held_values[idx+1];
          held_count--;
        end
      end
      default: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.popped = held_values[0];
          for (idx = 0; idx + 1 < held_count; idx++) held_values[idx] = held_values[idx+1];
          held_count--;
        end
      end
    endcase
    res.count = held_count[COUNT_OUT_W-1:0];
    expected_results.push_back(res);
  endtask

  // Request driver. A request stays on the port until the table takes it;
  // after each one a random gap is drawn before the next is offered.
  int req_gap_left = 0;

  always @(posedge clk) begin : drive_requests
    request_t req;
    logic     taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && in_ready;
      if (taken) predict_request(in_operation, in_value);
      if (in_valid && !taken) begin
        // Holding the current request; nothing changes on the port.
      end else if (req_gap_left > 0) begin
        req_gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req = pending_reqs.pop_front();
        in_valid     <= 1'b1;
        in_operation <= req.op;
        in_value     <= req.value;
        req_gap_left = draw_wait(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor. Each accepted result is compared field by field with the
  // oldest expectation; ready is pulled low for a random stall after each one.
  int res_stall_left = 0;

  always @(posedge clk) begin : check_results
    table_result_t exp_res;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request outstanding: status %0d popped %0d count %0d",
                   $time, out_status, out_popped_value, out_entry_count);
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_status !== exp_res.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, exp_res.status, out_status);
            error_count++;
          end
          if (out_popped_value !== exp_res.popped) begin
            $display("%0t: popped value mismatch: expected %0d, actual %0d",
                     $time, exp_res.popped, out_popped_value);
            error_count++;
          end
          if (out_entry_count !== exp_res.count) begin
            $display("%0t: entry count mismatch: expected %0d, actual %0d",
                     $time, exp_res.count, out_entry_count);
            error_count++;
          end
        end
        res_stall_left = draw_wait(1);
      end
      if (res_stall_left > 0) begin
        res_stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_request(input op_t op, input logic signed [VALUE_W-1:0] v);
    request_t req;
    req.op    = op;
    req.value = v;
    pending_reqs.push_back(req);
    if (op == OP_INSERT) begin
      inserted_history.push_back(v);
      if (inserted_history.size() > 32) void'(inserted_history.pop_front());
    end
  endtask

  // Operand mix: mostly a narrow band around zero so that duplicates and hits
  // are common, plus earlier inserted values, the extremes and full-range noise.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 4) return $signed($urandom_range(0, 16)) - 8;
    if (sel <= 7 && inserted_history.size() > 0)
      return inserted_history[$urandom_range(0, inserted_history.size() - 1)];
    if (sel == 9) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  // Picks an operation with weights that depend on the phase: filling phases
  // push the table to full, draining phases empty it, mixed phases do both.
  function automatic op_t pick_op(input int phase_kind);
    int roll;
    roll = $urandom_range(0, 99);
    case (phase_kind)
      0: begin
        if (roll < 70) return OP_INSERT;
        if (roll < 80) return OP_SEARCH;
        if (roll < 90) return OP_DELETE;
        return OP_POP;
      end
      1: begin
        if (roll < 10) return OP_INSERT;
        if (roll < 25) return OP_SEARCH;
        if (roll < 50) return OP_DELETE;
        return OP_POP;
      end
      default: return op_t'($urandom_range(0, 3));
    endcase
  endfunction

  initial begin : stimulus
    int made;
    int phase_kind;
    int phase_len;
    int k;

    // Empty-table cases for every operation that reads the table.
    add_request(OP_POP,    32'sd5);
    add_request(OP_SEARCH, 32'sd0);
    add_request(OP_DELETE, 32'sd0);
    // Extremes of the value field, and an equal value stored twice.
    add_request(OP_INSERT, 32'sh7FFF_FFFF);
    add_request(OP_INSERT, 32'sh8000_0000);
    add_request(OP_INSERT, 32'sd0);
    add_request(OP_INSERT, -32'sd1);
    add_request(OP_INSERT, 32'sd0);
    // A hit and a miss for search and for delete; the delete removes only
    // the first of the two equal zeros.
    add_request(OP_SEARCH, 32'sd0);
    add_request(OP_SEARCH, 32'sd5);
    add_request(OP_DELETE, 32'sd0);
    add_request(OP_DELETE, 32'sd7);
    // Fill the table to capacity, then try one more insert against a full table.
    for (k = 0; k < CAPACITY - 4; k++) add_request(OP_INSERT, $signed(32'(k * 3)) - 16);
    add_request(OP_INSERT, 32'sd1);
    add_request(OP_POP, 32'sh5555_AAAA);

    made = 0;
    while (made < RANDOM_ITEMS) begin
      phase_kind = $urandom_range(0, 2);
      phase_len  = $urandom_range(10, 40);
      for (k = 0; k < phase_len && made < RANDOM_ITEMS; k++) begin
        add_request(pick_op(phase_kind), pick_value());
        made++;
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Everything handed to the table and every result returned, then a settling
    // wait to catch any stray result.
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run of this request count.
  initial begin : watchdog
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/slt_pkg.sv
hw/rtl/slt_ctrl.sv
hw/rtl/slt_datapath.sv
hw/rtl/sorted_list_table.sv
tb/sv/tb_top.sv
